FILE: rtl/core/decimal_token_validator_defines.svh
// ---------------------------------------------------------------------------
// Decimal token validator assertion macros
// Shared concurrent assertion forms; expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_TOKEN_VALIDATOR_DEFINES_SVH
`define DECIMAL_TOKEN_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define DTV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dtv_pkg.sv
// ---------------------------------------------------------------------------
// Decimal token validator package
// Shared types and character codes.
// ---------------------------------------------------------------------------
package dtv_pkg;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_ZERO    = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } item_t;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_ONE  = 8'd49;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;

endpackage

FILE: rtl/core/dtv_token_core.sv
// ---------------------------------------------------------------------------
// Decimal token validator core
// Per-token state, updated on each taken item; verdict for the final item.
// ---------------------------------------------------------------------------
module dtv_token_core #(
  parameter int MAX_CHARS    = 6,
  parameter int MAX_DECIMALS = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  dtv_pkg::item_t item,
  output logic          verdict
);

  localparam int CW = $clog2(MAX_CHARS + 2);
  localparam int DW = $clog2(MAX_DECIMALS + 2);
  localparam logic [CW-1:0] CHARS_MAX = CW'(MAX_CHARS);
  localparam logic [CW-1:0] ZERO_LEN  = CW'(2 + MAX_DECIMALS);
  localparam logic [DW-1:0] DEC_MAX   = DW'(MAX_DECIMALS);

  logic [CW-1:0]  char_count, char_count_next;
  dtv_pkg::kind_t first_kind, first_kind_next;
  logic           second_ok, second_ok_next;
  logic           dot_seen, dot_seen_next;
  logic [DW-1:0]  decimals_count, decimals_count_next;
  logic [DW-1:0]  zero_count, zero_count_next;
  logic           any_bad, any_bad_next;
  logic           prev_was_dot, prev_was_dot_next;

  logic is_digit, is_nonzero, is_zero, is_dot;
  logic [DW-1:0] dec_inc;

  assign is_digit   = (item.character >= dtv_pkg::ASCII_ZERO) &&
                      (item.character <= dtv_pkg::ASCII_NINE);
  assign is_nonzero = (item.character >= dtv_pkg::ASCII_ONE) &&
                      (item.character <= dtv_pkg::ASCII_NINE);
  assign is_zero    = item.character == dtv_pkg::ASCII_ZERO;
  assign is_dot     = item.character == dtv_pkg::ASCII_DOT;
  assign dec_inc    = (decimals_count <= DEC_MAX) ? decimals_count + DW'(1) : decimals_count;

  always_comb begin
    char_count_next     = char_count;
    first_kind_next     = first_kind;
    second_ok_next      = second_ok;
    dot_seen_next       = dot_seen;
    decimals_count_next = decimals_count;
    zero_count_next     = zero_count;
    any_bad_next        = any_bad;
    prev_was_dot_next   = prev_was_dot;
    if (item.has_char) begin
      if (char_count == '0) begin
        priority if (is_nonzero) begin
          first_kind_next = dtv_pkg::KIND_NONZERO;
        end else if (is_zero) begin
          first_kind_next = dtv_pkg::KIND_ZERO;
        end else begin
          first_kind_next = dtv_pkg::KIND_OTHER;
          any_bad_next    = 1'b1;
        end
      end else begin
        if (char_count == CW'(1)) begin
          second_ok_next = (first_kind == dtv_pkg::KIND_ZERO) ? is_dot : is_digit;
        end
        if (first_kind == dtv_pkg::KIND_ZERO) begin
          if (char_count >= CW'(2)) begin
            if (!is_digit) begin
              any_bad_next = 1'b1;
            end else if (is_zero && zero_count <= DEC_MAX) begin
              zero_count_next = zero_count + DW'(1);
            end
          end
        end else begin
          if (!is_digit && !is_dot) begin
            any_bad_next = 1'b1;
          end
          if (is_dot) begin
            if (dot_seen) begin
              any_bad_next = 1'b1;
            end
            dot_seen_next = 1'b1;
          end else if (is_digit && dot_seen) begin
            decimals_count_next = dec_inc;
            if (dec_inc > DEC_MAX) begin
              any_bad_next = 1'b1;
            end
          end
        end
      end
      prev_was_dot_next = is_dot;
      if (char_count <= CHARS_MAX) begin
        char_count_next = char_count + CW'(1);
      end
    end
  end

  always_comb begin
    priority if (char_count_next == '0 || char_count_next > CHARS_MAX) begin
      verdict = 1'b0;
    end else if (char_count_next == CW'(1)) begin
      verdict = first_kind_next == dtv_pkg::KIND_NONZERO;
    end else if (char_count_next == CW'(2)) begin
      verdict = (first_kind_next == dtv_pkg::KIND_NONZERO) && second_ok_next;
    end else if (first_kind_next == dtv_pkg::KIND_ZERO) begin
      verdict = second_ok_next && !any_bad_next && (char_count_next <= ZERO_LEN) &&
                (CW'(zero_count_next) < char_count_next - CW'(2));
    end else begin
      verdict = !any_bad_next && !prev_was_dot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      char_count     <= '0;
      first_kind     <= dtv_pkg::KIND_NONE;
      second_ok      <= 1'b0;
      dot_seen       <= 1'b0;
      decimals_count <= '0;
      zero_count     <= '0;
      any_bad        <= 1'b0;
      prev_was_dot   <= 1'b0;
    end else if (take) begin
      char_count     <= char_count_next;
      first_kind     <= first_kind_next;
      second_ok      <= second_ok_next;
      dot_seen       <= dot_seen_next;
      decimals_count <= decimals_count_next;
      zero_count     <= zero_count_next;
      any_bad        <= any_bad_next;
      prev_was_dot   <= prev_was_dot_next;
    end
  end

endmodule

FILE: rtl/core/decimal_token_validator.sv
// ---------------------------------------------------------------------------
// Decimal token validator
// Streams one token character per request and returns one verdict per token.
// ---------------------------------------------------------------------------
// The block takes one character per cycle with no gaps required between
// tokens; only a waiting, untaken verdict stalls a further final request.
// Each request is held in an input register and folded into the per-token
// state as it leaves that register; the verdict for a token is registered
// on the output as the request marked tlast leaves the input register, and is
// held until taken. The sustained rate is one request per clock between stalls.
module decimal_token_validator #(
  parameter int MAX_CHARS    = 6,
  parameter int MAX_DECIMALS = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] character
  input  logic       s_axis_tuser,  // [0] has_char
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] accepted, [7:1] zero
);

  `include "decimal_token_validator_defines.svh"

  logic           in_valid;
  dtv_pkg::item_t in_item;
  logic           adv;
  logic           verdict;
  logic           accepted;

  assign adv           = in_valid && (!in_item.last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= '{character: s_axis_tdata, has_char: s_axis_tuser, last: s_axis_tlast};
    end
  end

  dtv_token_core #(
    .MAX_CHARS    (MAX_CHARS),
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (adv),
    .item    (in_item),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && in_item.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_item.last) begin
      accepted <= verdict;
    end
  end

  assign m_axis_tdata = {7'b0, accepted};

  `DTV_ASSERT_NXT(a_last_gives_result, adv && in_item.last, m_axis_tvalid,
                  "final request produced no result")
  `DTV_ASSERT_IMP(a_no_overwrite, m_axis_tvalid && !m_axis_tready,
                  !(adv && in_item.last), "waiting result overwritten")
  `DTV_ASSERT_IMP(a_empty_ready, !in_valid, s_axis_tready,
                  "empty input stage not ready")
  `DTV_ASSERT_NXT(a_nonlast_silent, !(adv && in_item.last) && !m_axis_tvalid,
                  !m_axis_tvalid, "result without final request")

endmodule
